/* rtl/core/ctsc_pkg.sv */
// ----------------------------------------------------------------------------
// ctsc_pkg
// shared types and constants of the clock time-set controller
// ----------------------------------------------------------------------------
package ctsc_pkg;

    // display code that blanks a digit
    localparam logic [3:0] DIGIT_BLANK = 4'd10;

    // highest packed bcd value of each edited field
    localparam logic [6:0] HOURS_TOP_BCD  = 7'h23;
    localparam logic [6:0] SIXTY_TOP_BCD  = 7'h59;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_HOURS   = 2'd1,
        MODE_MINUTES = 2'd2,
        MODE_SECONDS = 2'd3
    } mode_t;

    typedef struct packed {
        logic       set_press;
        logic       plus_press;
        logic       minus_press;
        logic [5:0] now_hours;
        logic [6:0] now_minutes;
        logic [6:0] now_seconds;
    } ctsc_in_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] digit_0;
        logic [3:0] digit_1;
        logic [3:0] digit_2;
        logic [3:0] digit_3;
        logic [3:0] digit_4;
        logic [3:0] digit_5;
        logic       write_time;
        logic [5:0] write_hours;
        logic [6:0] write_minutes;
        logic [6:0] write_seconds;
    } ctsc_out_t;

endpackage

/* rtl/core/ctsc_in_if.sv */
// ----------------------------------------------------------------------------
// ctsc_in_if
// key press and current time channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface ctsc_in_if;
    logic               valid;
    logic               ready;
    ctsc_pkg::ctsc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ctsc_out_if.sv */
// ----------------------------------------------------------------------------
// ctsc_out_if
// display digit and clock write channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface ctsc_out_if;
    logic                valid;
    logic                ready;
    ctsc_pkg::ctsc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ctsc_field_step.sv */
// ----------------------------------------------------------------------------
// ctsc_field_step
// one packed bcd step up or down with wrap at a given top value
// ----------------------------------------------------------------------------
module ctsc_field_step (
    input  logic [6:0] value,
    input  logic [6:0] top_bcd,
    input  logic       up,
    input  logic       down,
    output logic [6:0] stepped
);

    logic [3:0] units;
    logic [2:0] tens;

    assign units = value[3:0];
    assign tens  = value[6:4];

    always_comb
    begin
        stepped = value;
        // both keys on one transfer cancel out
        if (up && !down)
        begin
            if (value == top_bcd)
                stepped = 7'h00;
            else if (units == 4'd9)
                stepped = {tens + 3'd1, 4'd0};
            else
                stepped = {tens, units + 4'd1};
        end
        else if (down && !up)
        begin
            if (value == 7'h00)
                stepped = top_bcd;
            else if (units == 4'd0)
                stepped = {tens - 3'd1, 4'd9};
            else
                stepped = {tens, units - 4'd1};
        end
    end

endmodule

/* rtl/core/ctsc_ctrl.sv */
// ----------------------------------------------------------------------------
// ctsc_ctrl
// mode sequencer, edited time and display digit state
// ----------------------------------------------------------------------------
module ctsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  ctsc_pkg::ctsc_in_t  item,
    output ctsc_pkg::ctsc_out_t result
);

    ctsc_pkg::mode_t  mode_reg, mode_next;
    logic [5:0]       hours_reg, hours_next;
    logic [6:0]       minutes_reg, minutes_next;
    logic [6:0]       seconds_reg, seconds_next;
    logic             dirty_reg, dirty_next;
    logic [5:0][3:0]  shown_reg, shown_next;
    logic             wr;

    logic             step_h, step_m, step_s;
    logic [6:0]       hours_stepped, minutes_stepped, seconds_stepped;

    assign step_h = (mode_reg == ctsc_pkg::MODE_HOURS);
    assign step_m = (mode_reg == ctsc_pkg::MODE_MINUTES);
    assign step_s = (mode_reg == ctsc_pkg::MODE_SECONDS);

    ctsc_field_step u_step_hours (
        .value   ({1'b0, hours_reg}),
        .top_bcd (ctsc_pkg::HOURS_TOP_BCD),
        .up      (step_h && item.plus_press),
        .down    (step_h && item.minus_press),
        .stepped (hours_stepped)
    );

    ctsc_field_step u_step_minutes (
        .value   (minutes_reg),
        .top_bcd (ctsc_pkg::SIXTY_TOP_BCD),
        .up      (step_m && item.plus_press),
        .down    (step_m && item.minus_press),
        .stepped (minutes_stepped)
    );

    ctsc_field_step u_step_seconds (
        .value   (seconds_reg),
        .top_bcd (ctsc_pkg::SIXTY_TOP_BCD),
        .up      (step_s && item.plus_press),
        .down    (step_s && item.minus_press),
        .stepped (seconds_stepped)
    );

    assign hours_next   = hours_stepped[5:0];
    assign minutes_next = minutes_stepped;
    assign seconds_next = seconds_stepped;

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (item.set_press)
        begin
            unique case (mode_reg)
                ctsc_pkg::MODE_NORMAL:  mode_next = ctsc_pkg::MODE_HOURS;
                ctsc_pkg::MODE_HOURS:   mode_next = ctsc_pkg::MODE_MINUTES;
                ctsc_pkg::MODE_MINUTES: mode_next = ctsc_pkg::MODE_SECONDS;
                ctsc_pkg::MODE_SECONDS: mode_next = ctsc_pkg::MODE_NORMAL;
                default:                mode_next = ctsc_pkg::MODE_NORMAL;
            endcase
        end
    end

    // digits, dirty flag and write request
    always_comb
    begin
        shown_next = shown_reg;
        dirty_next = dirty_reg;
        wr         = 1'b0;
        if (mode_reg != ctsc_pkg::MODE_NORMAL && (item.plus_press || item.minus_press))
            dirty_next = 1'b1;
        unique case (mode_reg)
            ctsc_pkg::MODE_NORMAL:
            begin
                if (!item.set_press)
                    shown_next = {item.now_seconds[3:0],
                                  {1'b0, item.now_seconds[6:4]},
                                  item.now_minutes[3:0],
                                  {1'b0, item.now_minutes[6:4]},
                                  item.now_hours[3:0],
                                  {2'b00, item.now_hours[5:4]}};
            end
            ctsc_pkg::MODE_HOURS:
            begin
                if (!item.set_press)
                    shown_next = {ctsc_pkg::DIGIT_BLANK, ctsc_pkg::DIGIT_BLANK,
                                  ctsc_pkg::DIGIT_BLANK, ctsc_pkg::DIGIT_BLANK,
                                  hours_next[3:0], {2'b00, hours_next[5:4]}};
            end
            ctsc_pkg::MODE_MINUTES:
            begin
                if (!item.set_press)
                    shown_next = {ctsc_pkg::DIGIT_BLANK, ctsc_pkg::DIGIT_BLANK,
                                  minutes_next[3:0], {1'b0, minutes_next[6:4]},
                                  ctsc_pkg::DIGIT_BLANK, ctsc_pkg::DIGIT_BLANK};
            end
            ctsc_pkg::MODE_SECONDS:
            begin
                if (!item.set_press)
                    shown_next = {seconds_next[3:0], {1'b0, seconds_next[6:4]},
                                  ctsc_pkg::DIGIT_BLANK, ctsc_pkg::DIGIT_BLANK,
                                  ctsc_pkg::DIGIT_BLANK, ctsc_pkg::DIGIT_BLANK};
                else if (dirty_next)
                begin
                    // leaving seconds with an edited time: show it and load the clock
                    shown_next = {seconds_next[3:0], {1'b0, seconds_next[6:4]},
                                  minutes_next[3:0], {1'b0, minutes_next[6:4]},
                                  hours_next[3:0], {2'b00, hours_next[5:4]}};
                    wr         = 1'b1;
                    dirty_next = 1'b0;
                end
            end
            default:
            begin
                shown_next = shown_reg;
            end
        endcase
    end

    always_comb
    begin
        result.mode          = mode_next;
        result.digit_0       = shown_next[0];
        result.digit_1       = shown_next[1];
        result.digit_2       = shown_next[2];
        result.digit_3       = shown_next[3];
        result.digit_4       = shown_next[4];
        result.digit_5       = shown_next[5];
        result.write_time    = wr;
        result.write_hours   = wr ? hours_next   : 6'd0;
        result.write_minutes = wr ? minutes_next : 7'd0;
        result.write_seconds = wr ? seconds_next : 7'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ctsc_pkg::MODE_NORMAL;
            hours_reg   <= 6'd0;
            minutes_reg <= 7'd0;
            seconds_reg <= 7'd0;
            dirty_reg   <= 1'b0;
            shown_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            dirty_reg   <= dirty_next;
            shown_reg   <= shown_next;
        end
    end

endmodule

/* rtl/core/clock_time_set_controller_top.sv */
// ----------------------------------------------------------------------------
// clock_time_set_controller_top
// digital clock time-set controller: set/plus/minus keys to display and clock write
// ----------------------------------------------------------------------------
// Each transfer on items is one pass of the control loop: the debounced set,
// plus and minus press pulses and the current packed bcd time. The set key
// walks the mode through normal, hours, minutes, seconds and back to normal;
// in a set mode plus and minus step the edited field with bcd wrap (hours
// modulo 24, minutes and seconds modulo 60) and mark the time edited. Leaving
// seconds mode with an edited time raises write_time with the new time for one
// result. Each item gives exactly one result on results: the mode after the
// item, six display digits (10 = blank, unedited fields blanked, digits held
// on a mode change but for the write, which shows the new time) and the clock
// write. The block takes one item per clock unless results stalls: an item
// is captured in the input register, passes the mode and bcd step logic and
// lands in the result register; both registers advance together whenever the
// result side takes or has room. The edited time resets to 00:00:00 only on rst_n.
// ----------------------------------------------------------------------------
module clock_time_set_controller_top (
    input  logic     clk,
    input  logic     rst_n,
    ctsc_in_if.sink    items,
    ctsc_out_if.source results
);

    // input register
    logic                in_valid_reg, in_valid_next;
    ctsc_pkg::ctsc_in_t  in_data_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    ctsc_pkg::ctsc_out_t out_data_reg;

    logic                advance;
    logic                in_take;
    ctsc_pkg::ctsc_out_t result;

    // the held item moves on when the result register is empty or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready   = !in_valid_reg || advance;
    assign in_take       = items.valid && items.ready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !results.ready);

    ctsc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= items.data;
        if (advance)
            out_data_reg <= result;
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule
